>>> src/tdbf_pkg.sv
// ----------------------------------------------------------------------------
// tdbf_pkg
// Shared types and constants of the text display buffer formatter: frame
// geometry, command and result codes, controller states, inter-module structs.
// ----------------------------------------------------------------------------
`default_nettype none

package tdbf_pkg;

	// frame geometry
	localparam int COLUMNS    = 16;
	localparam int ROWS       = 2;
	localparam int FRAME_SIZE = ROWS * COLUMNS;
	localparam int COL_W      = $clog2(COLUMNS);
	localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int ADDR_W     = $clog2(FRAME_SIZE);

	// number formatting
	localparam int DEC_MAX_DIGITS = 8;
	localparam int BIN_MAX_DIGITS = 16;
	localparam int CNT_W          = $clog2(BIN_MAX_DIGITS + 1);
	localparam int NUM_W          = 32;
	localparam int BCD_W          = 4 * DEC_MAX_DIGITS;
	localparam int STEP_W         = $clog2(NUM_W);

	// field widths
	localparam int OP_W   = 4;
	localparam int KIND_W = 2;
	localparam int POS_W  = 5;
	localparam int CHAR_W = 8;

	// character codes
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_A     = 8'h41;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR  = 4'd0,
		OP_HOME   = 4'd1,
		OP_SETCUR = 4'd2,
		OP_PUT    = 4'd3,
		OP_DECB   = 4'd4,
		OP_DECP   = 4'd5,
		OP_HEX    = 4'd6,
		OP_BIN    = 4'd7,
		OP_UPDATE = 4'd8
	} op_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_ACK   = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_XFER  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACK,
		ST_CONV,
		ST_DIGIT,
		ST_DUMP_RD,
		ST_DUMP_WR
	} state_t;

	// one result item
	typedef struct packed {
		kind_t             kind;
		logic [POS_W-1:0]  position;
		logic [CHAR_W-1:0] char_out;
		logic              last;
	} res_t;

	// frame store access request
	typedef struct packed {
		logic              we;
		logic              clr;
		logic              re;
		logic [ADDR_W-1:0] addr;
		logic [CHAR_W-1:0] wdata;
	} store_req_t;

endpackage

`default_nettype wire

>>> src/tdbf_store.sv
// ----------------------------------------------------------------------------
// tdbf_store
// Character frame store: one synchronous memory with a registered read port.
// A per-entry valid vector makes never-written or cleared entries read as space.
// ----------------------------------------------------------------------------
`default_nettype none

module tdbf_store (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire tdbf_pkg::store_req_t      req,
	output logic [tdbf_pkg::CHAR_W-1:0]    rd_data
);
	import tdbf_pkg::*;

	logic [CHAR_W-1:0]     mem [FRAME_SIZE];
	logic [FRAME_SIZE-1:0] valid_q;
	logic [CHAR_W-1:0]     rd_data_q;

	// valid bits: cleared by reset and by the clear command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.clr) begin
			valid_q <= '0;
		end else if (req.we) begin
			valid_q[req.addr] <= 1'b1;
		end
	end

	// array write and registered read
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.re) begin
			rd_data_q <= valid_q[req.addr] ? mem[req.addr] : CH_SPACE;
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

>>> src/tdbf_bcd.sv
// ----------------------------------------------------------------------------
// tdbf_bcd
// Iterative binary to BCD converter (shift and add-3), one bit per cycle.
// Keeps the low eight decimal digits, i.e. the value modulo 10^8.
// ----------------------------------------------------------------------------
`default_nettype none

module tdbf_bcd (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [tdbf_pkg::NUM_W-1:0]  bin,
	output logic                             busy,
	output logic [tdbf_pkg::BCD_W-1:0]       bcd
);
	import tdbf_pkg::*;

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic [NUM_W-1:0]  bin_q;
	logic [BCD_W-1:0]  bcd_q;
	logic [BCD_W-1:0]  adj;

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < DEC_MAX_DIGITS; i++) begin
			adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
			                                          : bcd_q[4*i +: 4];
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(NUM_W - 1);
		end else if (busy_q) begin
			step_q <= step_q - 1'b1;
			if (step_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= bin;
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= {bin_q[NUM_W-2:0], 1'b0};
			bcd_q <= {adj[BCD_W-2:0], bin_q[NUM_W-1]};
		end
	end

	assign busy = busy_q;
	assign bcd  = bcd_q;

endmodule

`default_nettype wire

>>> src/tdbf_ctrl.sv
// ----------------------------------------------------------------------------
// tdbf_ctrl
// Command sequencer: decodes a command, keeps the cursor, drives the frame
// store and the converter, and produces result items one at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module tdbf_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cmd_valid,
	output logic                            cmd_ready,
	input  wire logic [tdbf_pkg::OP_W-1:0]  op,
	input  wire logic [7:0]                 row,
	input  wire logic [7:0]                 col,
	input  wire logic [7:0]                 ch,
	input  wire logic [tdbf_pkg::NUM_W-1:0] number,
	input  wire logic [7:0]                 digits,
	input  wire logic                       out_free,
	output logic                            res_valid,
	output tdbf_pkg::res_t                  res,
	output tdbf_pkg::store_req_t            store_req,
	input  wire logic [tdbf_pkg::CHAR_W-1:0] store_rd,
	output logic                            bcd_start,
	input  wire logic                       bcd_busy,
	input  wire logic [tdbf_pkg::BCD_W-1:0] bcd
);
	import tdbf_pkg::*;

	state_t            state_q, state_d;
	op_t               op_q;
	op_t               op_in;
	logic [CHAR_W-1:0] ch_q;
	logic [NUM_W-1:0]  number_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              shown_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [ADDR_W-1:0] idx_q;

	logic              accept;
	logic [CNT_W-1:0]  capped;
	logic [CNT_W-1:0]  k;
	logic [3:0]        nib;
	logic [3:0]        dec_d;
	logic [CHAR_W-1:0] dig_char;
	logic              dig_shown;
	logic [ADDR_W-1:0] cur_addr;
	logic              dump_end;

	assign op_in  = op_t'(op);
	assign accept = cmd_valid && cmd_ready;

	// digit count capped per format
	always_comb begin
		if (op_in == OP_BIN) begin
			capped = (digits > 8'(BIN_MAX_DIGITS)) ? CNT_W'(BIN_MAX_DIGITS) : digits[CNT_W-1:0];
		end else begin
			capped = (digits > 8'(DEC_MAX_DIGITS)) ? CNT_W'(DEC_MAX_DIGITS) : digits[CNT_W-1:0];
		end
	end

	// character for the current digit, most significant first
	assign k        = cnt_q - 1'b1;
	assign nib      = number_q[{k[2:0], 2'b00} +: 4];
	assign dec_d    = bcd[{k[2:0], 2'b00} +: 4];
	assign cur_addr = ADDR_W'(row_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_q);
	assign dump_end = (idx_q == ADDR_W'(FRAME_SIZE - 1));

	always_comb begin
		dig_shown = shown_q;
		case (op_q)
			OP_HEX: begin
				dig_char = (nib >= 4'd10) ? CH_A + CHAR_W'(nib - 4'd10) : CH_ZERO + CHAR_W'(nib);
			end
			OP_BIN: begin
				dig_char = CH_ZERO + CHAR_W'(number_q[k]);
			end
			OP_DECB, OP_DECP: begin
				dig_char = CH_ZERO + CHAR_W'(dec_d);
				// blank-padded decimal: leading zeros blank, the units digit always shows
				if (op_q == OP_DECB && !shown_q && dec_d == 4'd0 && k != '0) begin
					dig_char = CH_SPACE;
				end else begin
					dig_shown = 1'b1;
				end
			end
			default: begin
				dig_char = ch_q;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					case (op_in)
						OP_PUT:           state_d = ST_DIGIT;
						OP_DECB, OP_DECP: state_d = (capped == '0) ? ST_ACK : ST_CONV;
						OP_HEX, OP_BIN:   state_d = (capped == '0) ? ST_ACK : ST_DIGIT;
						OP_UPDATE:        state_d = ST_DUMP_RD;
						default:          state_d = ST_ACK;
					endcase
				end
			end
			ST_ACK: begin
				if (out_free) state_d = ST_IDLE;
			end
			ST_CONV: begin
				if (!bcd_busy) state_d = ST_DIGIT;
			end
			ST_DIGIT: begin
				if (out_free && cnt_q == CNT_W'(1)) state_d = ST_IDLE;
			end
			ST_DUMP_RD: begin
				state_d = ST_DUMP_WR;
			end
			ST_DUMP_WR: begin
				if (out_free) state_d = dump_end ? ST_IDLE : ST_DUMP_RD;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		cmd_ready       = 1'b0;
		res_valid       = 1'b0;
		res             = '{kind: KIND_ACK, position: '0, char_out: '0, last: 1'b1};
		store_req       = '0;
		store_req.addr  = cur_addr;
		store_req.wdata = dig_char;
		bcd_start       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd_ready     = 1'b1;
				store_req.clr = cmd_valid && op_in == OP_CLEAR;
				bcd_start     = cmd_valid && (op_in == OP_DECB || op_in == OP_DECP)
				                && capped != '0;
			end
			ST_ACK: begin
				res_valid = out_free;
			end
			ST_DIGIT: begin
				res_valid    = out_free;
				store_req.we = out_free;
				res          = '{kind: KIND_WRITE, position: POS_W'(cur_addr),
				                 char_out: dig_char, last: cnt_q == CNT_W'(1)};
			end
			ST_DUMP_RD: begin
				store_req.re   = 1'b1;
				store_req.addr = idx_q;
			end
			ST_DUMP_WR: begin
				res_valid      = out_free;
				store_req.addr = idx_q;
				res            = '{kind: KIND_XFER, position: POS_W'(idx_q),
				                   char_out: store_rd, last: dump_end};
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	// state and cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q   <= '0;
			row_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				case (op_in)
					OP_CLEAR, OP_HOME: begin
						col_q <= '0;
						row_q <= '0;
					end
					OP_SETCUR: begin
						col_q <= (col >= 8'(COLUMNS)) ? '0 : col[COL_W-1:0];
						row_q <= (row >= 8'(ROWS)) ? '0 : row[ROW_W-1:0];
					end
					default: begin
					end
				endcase
			end else if (store_req.we) begin
				// advance after each store write, wrapping rows and frame
				if (col_q == COL_W'(COLUMNS - 1)) begin
					col_q <= '0;
					row_q <= (row_q == ROW_W'(ROWS - 1)) ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	// command operands and counters
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= op_in;
			ch_q     <= ch;
			number_q <= number;
			cnt_q    <= (op_in == OP_PUT) ? CNT_W'(1) : capped;
			shown_q  <= 1'b0;
			idx_q    <= '0;
		end else begin
			if (store_req.we) begin
				cnt_q   <= cnt_q - 1'b1;
				shown_q <= dig_shown;
			end
			if (state_q == ST_DUMP_WR && out_free) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> src/text_display_buffer_formatter_unit.sv
// ----------------------------------------------------------------------------
// text_display_buffer_formatter_unit
// Character text buffer with cursor and number formatting, stream interface.
// ----------------------------------------------------------------------------
// Commands are taken one at a time on the slave stream and results leave on
// the master stream through an output register, so the next command is taken
// while the final result of the previous one still waits. Clear, home, set
// cursor, unused codes and zero-digit number commands give one acknowledge.
// Put char and hex/binary output write one character per cycle into the
// frame store while the output register is free. Decimal output first runs
// the shift-and-add-3 converter, one shift per bit of the 32-bit number, and
// waits for it to finish, then writes one digit per cycle while the output
// register is free. An update reads each of the 32 frame entries through the
// store's registered read port, a read state then a write state per entry.
// Clear needs no pass over the store: store entries carry valid bits, and an
// invalid entry reads as space. Downstream back-pressure holds every result.
// ----------------------------------------------------------------------------
`default_nettype none

module text_display_buffer_formatter_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // row[7:0], col[15:8], ch[23:16], number[55:24], digits[63:56]
	input  wire logic [3:0]  s_tuser,   // op[3:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // position[4:0], char_out[12:5], zero[15:13]
	output logic [1:0]       m_tuser,   // kind[1:0]
	output logic             m_tlast
);
	import tdbf_pkg::*;

	logic              out_free;
	logic              res_valid;
	res_t              res;
	store_req_t        store_req;
	logic [CHAR_W-1:0] store_rd;
	logic              bcd_start;
	logic              bcd_busy;
	logic [BCD_W-1:0]  bcd;

	logic              m_tvalid_q;
	res_t              m_res_q;

	tdbf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (s_tvalid),
		.cmd_ready (s_tready),
		.op        (s_tuser),
		.row       (s_tdata[7:0]),
		.col       (s_tdata[15:8]),
		.ch        (s_tdata[23:16]),
		.number    (s_tdata[55:24]),
		.digits    (s_tdata[63:56]),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res       (res),
		.store_req (store_req),
		.store_rd  (store_rd),
		.bcd_start (bcd_start),
		.bcd_busy  (bcd_busy),
		.bcd       (bcd)
	);

	tdbf_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (store_req),
		.rd_data (store_rd)
	);

	tdbf_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (bcd_start),
		.bin    (s_tdata[55:24]),
		.busy   (bcd_busy),
		.bcd    (bcd)
	);

	// output register: free when empty or being drained this cycle
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			m_res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, m_res_q.char_out, m_res_q.position};
	assign m_tuser  = m_res_q.kind;
	assign m_tlast  = m_res_q.last;

endmodule

`default_nettype wire

>>> src/tdbf_checker.sv
// ----------------------------------------------------------------------------
// tdbf_checker
// Port-level checks of the text display buffer formatter, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module tdbf_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [15:0] m_tdata,
	input  wire logic [1:0]  m_tuser,
	input  wire logic        m_tlast
);
	import tdbf_pkg::*;

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
		                          && $stable(m_tlast))
		else $error("stalled result changed");

	// one command at a time: a new transfer is not taken right after one
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("command taken while previous one still starting");

	// while a command still has results to give, no new command is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("command accepted before previous command finished");

	// acknowledges are single, empty results
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_ACK |-> m_tlast && m_tdata == 16'd0)
		else $error("malformed acknowledge");

	// no result kind beyond the defined ones
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser == KIND_ACK || m_tuser == KIND_WRITE || m_tuser == KIND_XFER)
		else $error("undefined result kind");

endmodule

bind text_display_buffer_formatter_unit tdbf_checker u_tdbf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire

>>> bench/text_display_buffer_formatter_unit_tb.sv
// ----------------------------------------------------------------------------
// text_display_buffer_formatter_unit_tb
// Self-checking bench for the character text buffer with number formatting.
// ----------------------------------------------------------------------------
// Commands go in on the slave stream. A behavioral copy of the frame store
// and cursor predicts every result for each accepted command. Results on the
// master stream are checked in order against that prediction. A directed set
// covers field extremes, cursor wrap, range clamping, digit capping and the
// unused op codes. Random commands then run under four idle/stall mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module text_display_buffer_formatter_unit_tb;

	import tdbf_pkg::*;

	localparam int          IDLE_LIMIT      = 2000;
	localparam int          DRAIN_CYCLES    = 100;
	localparam logic [3:0]  OP_FIRST_UNUSED = 4'd9;
	localparam logic [3:0]  OP_LAST_UNUSED  = 4'd15;

	// expected result of one transfer on the master side
	typedef struct packed {
		kind_t             kind;
		logic [POS_W-1:0]  position;
		logic [CHAR_W-1:0] char_out;
		logic              last;
	} disp_result_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata  = '0;
	logic [3:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	// predicted frame store and cursor
	logic [CHAR_W-1:0] frame_shadow [FRAME_SIZE];
	int                cursor_col_shadow;
	int                cursor_row_shadow;
	disp_result_t      expected_results [$];

	int gap_pct   = 0;
	int stall_pct = 0;
	int error_count;
	int idle_cycles;
	int cmd_count;
	int update_count;
	int number_count;
	int result_count;

	text_display_buffer_formatter_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #1 clk = ~clk;

	// receiver back-pressure
	always @(negedge clk) begin
		m_tready = ($urandom_range(0, 99) >= stall_pct);
	end

	// store one character at the cursor and advance with wrap
	task automatic shadow_put(input logic [CHAR_W-1:0] c, input logic fin);
		int idx;
		idx = cursor_row_shadow * COLUMNS + cursor_col_shadow;
		frame_shadow[idx] = c;
		expected_results.push_back('{KIND_WRITE, idx[POS_W-1:0], c, fin});
		cursor_col_shadow++;
		if (cursor_col_shadow >= COLUMNS) begin
			cursor_col_shadow = 0;
			cursor_row_shadow++;
		end
		if (cursor_row_shadow >= ROWS)
			cursor_row_shadow = 0;
	endtask

	// predict the results of one accepted command
	task automatic predict_command(input logic [3:0] op, input logic [7:0] row,
		input logic [7:0] col, input logic [7:0] ch, input logic [31:0] number,
		input logic [7:0] digits);
		int          cap;
		int          count;
		int unsigned value;
		int unsigned d;
		logic [7:0]  c;
		logic        shown;
		cmd_count++;
		case (op)
			OP_CLEAR: begin
				foreach (frame_shadow[i])
					frame_shadow[i] = CH_SPACE;
				cursor_col_shadow = 0;
				cursor_row_shadow = 0;
				expected_results.push_back('{KIND_ACK, '0, '0, 1'b1});
			end
			OP_HOME: begin
				cursor_col_shadow = 0;
				cursor_row_shadow = 0;
				expected_results.push_back('{KIND_ACK, '0, '0, 1'b1});
			end
			OP_SETCUR: begin
				cursor_col_shadow = (col >= COLUMNS) ? 0 : int'(col);
				cursor_row_shadow = (row >= ROWS) ? 0 : int'(row);
				expected_results.push_back('{KIND_ACK, '0, '0, 1'b1});
			end
			OP_PUT: shadow_put(ch, 1'b1);
			OP_DECB, OP_DECP, OP_HEX, OP_BIN: begin
				number_count++;
				cap   = (op == OP_BIN) ? BIN_MAX_DIGITS : DEC_MAX_DIGITS;
				count = (digits > cap) ? cap : int'(digits);
				shown = 1'b0;
				if (count == 0)
					expected_results.push_back('{KIND_ACK, '0, '0, 1'b1});
				for (int k = count - 1; k >= 0; k--) begin
					if (op == OP_HEX) begin
						d = (number >> (4 * k)) & 32'hF;
						c = (d >= 10) ? CH_A + 8'(d - 10) : CH_ZERO + 8'(d);
					end else if (op == OP_BIN) begin
						d = (number >> k) & 32'h1;
						c = CH_ZERO + 8'(d);
					end else begin
						value = number % 100000000;
						for (int j = 0; j < k; j++)
							value = value / 10;
						d = value % 10;
						c = CH_ZERO + 8'(d);
						// leading-zero blanking keeps the units digit
						if (op == OP_DECB) begin
							if (!shown && d == 0 && k != 0)
								c = CH_SPACE;
							else
								shown = 1'b1;
						end
					end
					shadow_put(c, k == 0);
				end
			end
			OP_UPDATE: begin
				update_count++;
				for (int i = 0; i < FRAME_SIZE; i++)
					expected_results.push_back('{KIND_XFER, POS_W'(i), frame_shadow[i],
						i == FRAME_SIZE - 1});
			end
			default: expected_results.push_back('{KIND_ACK, '0, '0, 1'b1});
		endcase
	endtask

	// drive one command and wait for its transfer
	task automatic send_command(input logic [3:0] op, input logic [7:0] row,
		input logic [7:0] col, input logic [7:0] ch, input logic [31:0] number,
		input logic [7:0] digits);
		@(negedge clk);
		while ($urandom_range(0, 99) < gap_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = op;
		s_tdata  = {digits, number, ch, col, row};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_command(op, row, col, ch, number, digits);
	endtask

	// check each result transfer against the oldest prediction
	always @(posedge clk) begin
		disp_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			result_count++;
			if (expected_results.size() == 0) begin
				error_count++;
				$display("%0t: unexpected result kind %0d pos %0d char %h last %b", $time,
					m_tuser, m_tdata[4:0], m_tdata[12:5], m_tlast);
			end else begin
				want = expected_results.pop_front();
				if (m_tuser !== want.kind || m_tdata[4:0] !== want.position
					|| m_tdata[12:5] !== want.char_out || m_tlast !== want.last
					|| m_tdata[15:13] !== 3'b000) begin
					error_count++;
					$display("%0t: mismatch expected kind %0d pos %0d char %h last %b pad 0",
						$time, want.kind, want.position, want.char_out, want.last);
					$display("%0t:          actual   kind %0d pos %0d char %h last %b pad %0d",
						$time, m_tuser, m_tdata[4:0], m_tdata[12:5], m_tlast,
						m_tdata[15:13]);
				end
			end
		end
	end

	// watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
				$display("status: fail");
				$finish;
			end
		end
	end

	// extremes, wrap, clamping, digit caps, zero digits, unused codes
	task automatic test_directed_cases();
		send_command(OP_UPDATE, 8'h00, 8'h00, 8'h00, 32'h0, 8'h00);
		send_command(OP_PUT, 8'hFF, 8'hFF, 8'h00, 32'hFFFFFFFF, 8'hFF);
		send_command(OP_PUT, 8'h00, 8'h00, 8'hFF, 32'h0, 8'h00);
		send_command(OP_SETCUR, 8'd1, 8'd15, 8'h00, 32'h0, 8'h00);
		send_command(OP_PUT, 8'h00, 8'h00, 8'h5A, 32'h0, 8'h00);
		send_command(OP_PUT, 8'h00, 8'h00, 8'h61, 32'h0, 8'h00);
		send_command(OP_SETCUR, 8'd2, 8'd16, 8'h00, 32'h0, 8'h00);
		send_command(OP_SETCUR, 8'hFF, 8'hFF, 8'h00, 32'h0, 8'h00);
		send_command(OP_SETCUR, 8'd1, 8'd3, 8'h00, 32'h0, 8'h00);
		send_command(OP_HOME, 8'h00, 8'h00, 8'h00, 32'h0, 8'h00);
		send_command(OP_DECB, 8'h00, 8'h00, 8'h00, 32'h0, 8'd8);
		send_command(OP_DECB, 8'h00, 8'h00, 8'h00, 32'hFFFFFFFF, 8'hFF);
		send_command(OP_DECP, 8'h00, 8'h00, 8'h00, 32'd12, 8'd3);
		send_command(OP_DECP, 8'h00, 8'h00, 8'h00, 32'hFFFFFFFF, 8'd9);
		send_command(OP_HEX, 8'h00, 8'h00, 8'h00, 32'hDEADBEEF, 8'd8);
		send_command(OP_HEX, 8'h00, 8'h00, 8'h00, 32'hFFFFFFFF, 8'd200);
		send_command(OP_BIN, 8'h00, 8'h00, 8'h00, 32'h0000A5A5, 8'd16);
		send_command(OP_BIN, 8'h00, 8'h00, 8'h00, 32'hFFFFFFFF, 8'hFF);
		send_command(OP_DECB, 8'h00, 8'h00, 8'h00, 32'd5, 8'd0);
		send_command(OP_HEX, 8'h00, 8'h00, 8'h00, 32'h0000000C, 8'd1);
		send_command(OP_FIRST_UNUSED, 8'hFF, 8'hFF, 8'hFF, 32'hFFFFFFFF, 8'hFF);
		send_command(OP_LAST_UNUSED, 8'h00, 8'h00, 8'h00, 32'h0, 8'h00);
		send_command(OP_UPDATE, 8'h00, 8'h00, 8'h00, 32'h0, 8'h00);
		send_command(OP_CLEAR, 8'h00, 8'h00, 8'h00, 32'h0, 8'h00);
		send_command(OP_UPDATE, 8'h00, 8'h00, 8'h00, 32'h0, 8'h00);
	endtask

	// weighted random command mix with random content in every field
	task automatic test_random_commands(input int count);
		int          pick;
		logic [3:0]  op;
		logic [7:0]  row;
		logic [7:0]  col;
		logic [31:0] number;
		logic [7:0]  digits;
		for (int n = 0; n < count; n++) begin
			pick   = $urandom_range(0, 99);
			row    = 8'($urandom_range(0, 255));
			col    = 8'($urandom_range(0, 255));
			number = ($urandom_range(0, 99) < 70) ? ($urandom >> $urandom_range(0, 31))
				: $urandom;
			digits = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 17))
				: 8'($urandom_range(0, 255));
			if (pick < 2)       op = OP_CLEAR;
			else if (pick < 5)  op = OP_HOME;
			else if (pick < 15) op = OP_SETCUR;
			else if (pick < 40) op = OP_PUT;
			else if (pick < 52) op = OP_DECB;
			else if (pick < 62) op = OP_DECP;
			else if (pick < 74) op = OP_HEX;
			else if (pick < 86) op = OP_BIN;
			else if (pick < 94) op = OP_UPDATE;
			else                op = 4'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
			// mostly valid cursor positions, some out of range
			if (op == OP_SETCUR && $urandom_range(0, 99) < 80) begin
				row = 8'($urandom_range(0, ROWS - 1));
				col = 8'($urandom_range(0, COLUMNS - 1));
			end
			send_command(op, row, col, 8'($urandom_range(0, 255)), number, digits);
		end
	endtask

	initial begin
		error_count  = 0;
		idle_cycles  = 0;
		cmd_count    = 0;
		update_count = 0;
		number_count = 0;
		result_count = 0;
		foreach (frame_shadow[i])
			frame_shadow[i] = CH_SPACE;
		cursor_col_shadow = 0;
		cursor_row_shadow = 0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_cases();
		gap_pct = 0;  stall_pct = 0;  test_random_commands(108);
		gap_pct = 61; stall_pct = 0;  test_random_commands(108);
		gap_pct = 0;  stall_pct = 61; test_random_commands(108);
		gap_pct = 23; stall_pct = 23; test_random_commands(108);

		@(negedge clk);
		s_tvalid = 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d commands (%0d frame dumps, %0d number formats), %0d results checked",
			cmd_count, update_count, number_count, result_count);
		$display("under no idling, sender gaps, receiver stalls and both combined.");
		if (error_count == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d errors", error_count);
			$display("status: fail");
		end
		$finish;
	end

endmodule

>>> text_display_buffer_formatter_unit.f
src/tdbf_pkg.sv
src/tdbf_store.sv
src/tdbf_bcd.sv
src/tdbf_ctrl.sv
src/text_display_buffer_formatter_unit.sv
src/tdbf_checker.sv
bench/text_display_buffer_formatter_unit_tb.sv
